### design/mau_pkg.sv
// ----------------------------------------------------------------------------
// mau_pkg
// Shared types and constants of the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

   localparam int MOD_WIDTH     = 30;
   localparam int WIDE_WIDTH    = 64;
   localparam int COEF_WIDTH    = 32;
   localparam int PROD_WIDTH    = 2 * MOD_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(WIDE_WIDTH);
   localparam logic [MOD_WIDTH-1:0] RESET_MODULUS = MOD_WIDTH'(10009);

   // Operation codes carried in the request user field
   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_NEG = 3'd4,
      OP_POW = 3'd5,
      OP_INV = 3'd6,
      OP_RED = 3'd7
   } op_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_RA,
      ST_MUL_RB,
      ST_MUL_RP,
      ST_NEG_R,
      ST_RED,
      ST_POW_BASE,
      ST_POW_CHK,
      ST_POW_MUL,
      ST_POW_SQ,
      ST_EUC_CHK,
      ST_EUC_DIV,
      ST_EUC_UPD,
      ST_EUC_FOLD,
      ST_OUT
   } state_type;

   // Divider request and response
   typedef struct packed {
      logic                  start;
      logic [WIDE_WIDTH-1:0] dividend;
      logic [MOD_WIDTH-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [WIDE_WIDTH-1:0] quotient;
      logic [MOD_WIDTH-1:0]  remainder;
   } div_rsp_type;

endpackage

### design/mau_div.sv
// ----------------------------------------------------------------------------
// mau_div
// Restoring divider: 64-bit unsigned dividend by a 30-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module mau_div (
   input  logic                  clock,
   input  logic                  reset,
   input  mau_pkg::div_req_type  div_req,
   output mau_pkg::div_rsp_type  div_rsp
);

   logic [mau_pkg::WIDE_WIDTH-1:0]    quo_ff, quo_in;
   logic [mau_pkg::MOD_WIDTH-1:0]     rem_ff, rem_in;
   logic [mau_pkg::MOD_WIDTH-1:0]     dsr_ff, dsr_in;
   logic [mau_pkg::DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [mau_pkg::MOD_WIDTH:0]       trial;
   logic                              fits;

   // one restoring step
   assign trial = {rem_ff, quo_ff[mau_pkg::WIDE_WIDTH-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[mau_pkg::WIDE_WIDTH-2:0], fits};
         rem_in = fits ? mau_pkg::MOD_WIDTH'(trial - {1'b0, dsr_ff})
                       : trial[mau_pkg::MOD_WIDTH-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

### design/modular_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_core
// Modular arithmetic over a programmable modulus, one operation per request.
// ----------------------------------------------------------------------------
// Requests arrive on req_* (operation in tuser, operands in tdata); each gives
// one residue on rsp_*. The modulus is to be written over the csr_* port
// (address 0) by the user only while the block is idle; the block does not
// enforce this. The block takes one request at a time: req_tready is high
// only while idle, and the result is held in rsp_tdata until taken.
// Reductions other than the add/sub correction use the 64-step restoring divider:
//   add, sub, tiny modulus, pow with exponent <= 0 : no divider pass
//   neg, reduce : a single pass;  mul : each operand, then the product
//   pow : the base, then per exponent bit a multiply if set and a square
//   inverse : a divide per Euclid step, then a sign fold; div adds a mul
// Reset restores the modulus to 10009 and returns the block to idle. When the
// receiver stalls the result waits in its register and no request is taken.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_core (
   input  logic         clock,
   input  logic         reset,
   // request: tdata = operand_a[29:0], operand_b[59:30], wide_operand[123:60]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,
   // request: tuser = operation[2:0]
   input  logic [2:0]   req_tuser,
   // response: tdata = residue[29:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,
   // configuration
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int MW = mau_pkg::MOD_WIDTH;
   localparam int WW = mau_pkg::WIDE_WIDTH;
   localparam int CW = mau_pkg::COEF_WIDTH;
   localparam int PW = mau_pkg::PROD_WIDTH;

   mau_pkg::state_type   state_ff, state_in;
   mau_pkg::op_type      op_ff;
   mau_pkg::div_req_type div_req;
   mau_pkg::div_rsp_type div_rsp;

   logic          go_ff;
   logic [MW-1:0] mod_ff;
   logic [MW-1:0] a_ff, b_ff, ra_ff, ret_ff, sq_ff, res_ff;
   logic [MW-1:0] ea_ff, eb_ff, q_ff;
   logic [CW-1:0] eu_ff, ev_ff;
   logic [WW-1:0] w_ff, e_ff;

   logic          accept;
   logic [MW-1:0] in_a, in_b;
   logic [WW-1:0] in_w;
   mau_pkg::op_type in_op;
   logic          tiny_mod;
   logic          pow_trivial;
   logic [MW+2:0] quick_sum;
   logic [MW-1:0] quick_res;
   logic [MW-1:0] mul_x, mul_y;
   logic [PW-1:0] prod;
   logic [CW-1:0] ev_mag;
   logic [WW-1:0] nu_wide;
   logic          fold_neg;
   logic [MW-1:0] fold_res;
   logic          csr_write;

   // ---------------- configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {{(32-MW){1'b0}}, mod_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= mau_pkg::RESET_MODULUS;
      end else if (csr_write && !csr_paddr[2]) begin
         mod_ff <= csr_pwdata[MW-1:0];
      end
   end

   // ---------------- request unpacking and quick add/sub results
   assign in_a   = req_tdata[MW-1:0];
   assign in_b   = req_tdata[2*MW-1:MW];
   assign in_w   = req_tdata[2*MW+WW-1:2*MW];
   assign in_op  = mau_pkg::op_type'(req_tuser);
   assign accept = req_tvalid & req_tready;

   assign tiny_mod    = mod_ff < MW'(2);
   assign pow_trivial = in_w[WW-1] || (in_w == '0);

   // add: a+b, sub: a+(m-b); one correction, negative means wrapped
   always_comb begin
      if (in_op == mau_pkg::OP_ADD) begin
         quick_sum = {3'b000, in_a} + {3'b000, in_b};
      end else begin
         quick_sum = {3'b000, in_a} + {3'b000, mod_ff} - {3'b000, in_b};
      end
      if (quick_sum[MW+2] || (quick_sum >= {3'b000, mod_ff})) begin
         quick_res = MW'(quick_sum - {3'b000, mod_ff});
      end else begin
         quick_res = quick_sum[MW-1:0];
      end
   end

   // ---------------- shared multiplier
   assign ev_mag = ev_ff[CW-1] ? (~ev_ff + 1'b1) : ev_ff;

   always_comb begin
      unique case (state_ff)
         mau_pkg::ST_POW_MUL: begin
            mul_x = ret_ff;
            mul_y = sq_ff;
         end
         mau_pkg::ST_POW_SQ: begin
            mul_x = sq_ff;
            mul_y = sq_ff;
         end
         mau_pkg::ST_EUC_UPD: begin
            mul_x = q_ff;
            mul_y = ev_mag[MW-1:0];
         end
         default: begin
            mul_x = ra_ff;
            mul_y = b_ff;
         end
      endcase
   end

   assign prod = mul_x * mul_y;

   // new Euclid coefficient u - q*v
   assign nu_wide = {{(WW-CW){eu_ff[CW-1]}}, eu_ff}
                  - (ev_ff[CW-1] ? (~{{(WW-PW){1'b0}}, prod} + 1'b1)
                                 : {{(WW-PW){1'b0}}, prod});

   // sign fold of a remainder
   assign fold_neg = (state_ff == mau_pkg::ST_RED)      ? w_ff[WW-1] :
                     (state_ff == mau_pkg::ST_EUC_FOLD) ? eu_ff[CW-1] : 1'b1;
   assign fold_res = (fold_neg && (div_rsp.remainder != '0))
                   ? mod_ff - div_rsp.remainder : div_rsp.remainder;

   // ---------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mau_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (tiny_mod) begin
                  state_in = mau_pkg::ST_OUT;
               end else begin
                  unique case (in_op)
                     mau_pkg::OP_ADD, mau_pkg::OP_SUB: state_in = mau_pkg::ST_OUT;
                     mau_pkg::OP_MUL: state_in = mau_pkg::ST_MUL_RA;
                     mau_pkg::OP_DIV, mau_pkg::OP_INV: state_in = mau_pkg::ST_EUC_CHK;
                     mau_pkg::OP_NEG: state_in = mau_pkg::ST_NEG_R;
                     mau_pkg::OP_POW: state_in = pow_trivial ? mau_pkg::ST_OUT
                                                             : mau_pkg::ST_POW_BASE;
                     default: state_in = mau_pkg::ST_RED;
                  endcase
               end
            end
         end
         mau_pkg::ST_MUL_RA:   if (div_rsp.done) state_in = mau_pkg::ST_MUL_RB;
         mau_pkg::ST_MUL_RB:   if (div_rsp.done) state_in = mau_pkg::ST_MUL_RP;
         mau_pkg::ST_MUL_RP:   if (div_rsp.done) state_in = mau_pkg::ST_OUT;
         mau_pkg::ST_NEG_R:    if (div_rsp.done) state_in = mau_pkg::ST_OUT;
         mau_pkg::ST_RED:      if (div_rsp.done) state_in = mau_pkg::ST_OUT;
         mau_pkg::ST_POW_BASE: if (div_rsp.done) state_in = mau_pkg::ST_POW_CHK;
         mau_pkg::ST_POW_CHK: begin
            priority if (e_ff == '0) state_in = mau_pkg::ST_OUT;
            else if (e_ff[0])        state_in = mau_pkg::ST_POW_MUL;
            else                     state_in = mau_pkg::ST_POW_SQ;
         end
         mau_pkg::ST_POW_MUL:  if (div_rsp.done) state_in = mau_pkg::ST_POW_SQ;
         mau_pkg::ST_POW_SQ:   if (div_rsp.done) state_in = mau_pkg::ST_POW_CHK;
         mau_pkg::ST_EUC_CHK: begin
            state_in = (eb_ff == '0) ? mau_pkg::ST_EUC_FOLD : mau_pkg::ST_EUC_DIV;
         end
         mau_pkg::ST_EUC_DIV:  if (div_rsp.done) state_in = mau_pkg::ST_EUC_UPD;
         mau_pkg::ST_EUC_UPD:  state_in = mau_pkg::ST_EUC_CHK;
         mau_pkg::ST_EUC_FOLD: begin
            if (div_rsp.done) begin
               state_in = (op_ff == mau_pkg::OP_INV) ? mau_pkg::ST_OUT
                                                     : mau_pkg::ST_MUL_RA;
            end
         end
         mau_pkg::ST_OUT:      if (rsp_tready) state_in = mau_pkg::ST_IDLE;
         default:              state_in = mau_pkg::ST_IDLE;
      endcase
   end

   // ---------------- outputs and divider launch
   always_comb begin
      req_tready       = (state_ff == mau_pkg::ST_IDLE);
      rsp_tvalid       = (state_ff == mau_pkg::ST_OUT);
      rsp_tdata        = {{(32-MW){1'b0}}, res_ff};
      div_req.start    = 1'b0;
      div_req.divisor  = mod_ff;
      div_req.dividend = '0;
      unique case (state_ff)
         mau_pkg::ST_MUL_RA, mau_pkg::ST_NEG_R, mau_pkg::ST_POW_BASE: begin
            div_req.start    = go_ff;
            div_req.dividend = {{(WW-MW){1'b0}}, a_ff};
         end
         mau_pkg::ST_MUL_RB: begin
            div_req.start    = go_ff;
            div_req.dividend = {{(WW-MW){1'b0}}, b_ff};
         end
         mau_pkg::ST_MUL_RP, mau_pkg::ST_POW_MUL, mau_pkg::ST_POW_SQ: begin
            div_req.start    = go_ff;
            div_req.dividend = {{(WW-PW){1'b0}}, prod};
         end
         mau_pkg::ST_RED: begin
            div_req.start    = go_ff;
            div_req.dividend = w_ff[WW-1] ? (~w_ff + 1'b1) : w_ff;
         end
         mau_pkg::ST_EUC_DIV: begin
            div_req.start    = go_ff;
            div_req.divisor  = eb_ff;
            div_req.dividend = {{(WW-MW){1'b0}}, ea_ff};
         end
         mau_pkg::ST_EUC_FOLD: begin
            div_req.start    = go_ff;
            div_req.dividend = {{(WW-CW){1'b0}},
                                eu_ff[CW-1] ? (~eu_ff + 1'b1) : eu_ff};
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   mau_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mau_pkg::ST_IDLE;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= (state_in != state_ff);
      end
   end

   // ---------------- datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         mau_pkg::ST_IDLE: begin
            if (accept) begin
               op_ff  <= in_op;
               a_ff   <= in_a;
               b_ff   <= in_b;
               w_ff   <= in_w;
               e_ff   <= in_w;
               ret_ff <= MW'(1);
               ea_ff  <= (in_op == mau_pkg::OP_DIV) ? in_b : in_a;
               eb_ff  <= mod_ff;
               eu_ff  <= CW'(1);
               ev_ff  <= '0;
               priority if (tiny_mod)                res_ff <= '0;
               else if (in_op == mau_pkg::OP_POW)    res_ff <= MW'(1);
               else                                  res_ff <= quick_res;
            end
         end
         mau_pkg::ST_MUL_RA:   if (div_rsp.done) ra_ff  <= div_rsp.remainder;
         mau_pkg::ST_MUL_RB:   if (div_rsp.done) b_ff   <= div_rsp.remainder;
         mau_pkg::ST_MUL_RP:   if (div_rsp.done) res_ff <= div_rsp.remainder;
         mau_pkg::ST_NEG_R, mau_pkg::ST_RED: begin
            if (div_rsp.done) res_ff <= fold_res;
         end
         mau_pkg::ST_POW_BASE: if (div_rsp.done) sq_ff  <= div_rsp.remainder;
         mau_pkg::ST_POW_CHK:  res_ff <= ret_ff;
         mau_pkg::ST_POW_MUL:  if (div_rsp.done) ret_ff <= div_rsp.remainder;
         mau_pkg::ST_POW_SQ: begin
            if (div_rsp.done) begin
               sq_ff <= div_rsp.remainder;
               e_ff  <= {1'b0, e_ff[WW-1:1]};
            end
         end
         mau_pkg::ST_EUC_DIV: begin
            if (div_rsp.done) begin
               q_ff  <= div_rsp.quotient[MW-1:0];
               ea_ff <= eb_ff;
               eb_ff <= div_rsp.remainder;
            end
         end
         mau_pkg::ST_EUC_UPD: begin
            eu_ff <= ev_ff;
            ev_ff <= nu_wide[CW-1:0];
         end
         mau_pkg::ST_EUC_FOLD: begin
            if (div_rsp.done) begin
               res_ff <= fold_res;
               b_ff   <= fold_res;
            end
         end
         default: begin
            res_ff <= res_ff;
         end
      endcase
   end

endmodule

### design/mau_checker.sv
// ----------------------------------------------------------------------------
// mau_checker
// Port-level checks of the modular arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module mau_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata
);

   // a held response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // one request at a time: never ready while a result is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("ready while a response is pending");

   // after a request is taken the block is busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accepting a request");

   // residues never use the padding bits
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:30] == 2'b00)
      else $error("response padding not zero");

endmodule

bind modular_arithmetic_unit_core mau_checker u_mau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
